// ===== sv/eud_pkg.sv =====
// ----------------------------------------------------------------------------
// eud_pkg
// Shared widths and control types for the Euclidean distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package eud_pkg;

    // Coordinate and result widths.
    localparam int COORD_W    = 16;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = 45;
    localparam int DIST_W     = 23;

    // Square root sequencer: one result bit per step, two operand bits per step.
    localparam int ROOT_STEPS = DIST_W;
    localparam int OPND_W     = 2 * ROOT_STEPS;
    localparam int REM_W      = DIST_W + 2;
    localparam int STEP_CNT_W = $clog2(ROOT_STEPS + 1);

    // Controls from the sequencer to the sum-of-squares datapath.
    typedef struct packed {
        logic clear;
        logic square_en;
        logic acc_en;
    } sq_ctrl_t;

    // Status of the square root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

`default_nettype wire

// ===== sv/eud_sqsum.sv =====
// ----------------------------------------------------------------------------
// eud_sqsum
// Squared difference and saturating running sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module eud_sqsum (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire eud_pkg::sq_ctrl_t             ctrl,
    input  wire logic [eud_pkg::COORD_W-1:0]   coord_a,
    input  wire logic [eud_pkg::COORD_W-1:0]   coord_b,
    output logic      [eud_pkg::SUM_W-1:0]     sum,
    output logic                               overflow
);

    logic [eud_pkg::COORD_W-1:0] diff;
    logic [eud_pkg::SQ_W-1:0]    sq_reg;
    logic [eud_pkg::SQ_W-1:0]    sq_next;
    logic [eud_pkg::SUM_W-1:0]   sum_reg;
    logic [eud_pkg::SUM_W-1:0]   sum_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic [eud_pkg::SUM_W:0]     total;

    assign diff    = (coord_a >= coord_b) ? (coord_a - coord_b) : (coord_b - coord_a);
    assign sq_next = diff * diff;
    assign total   = {1'b0, sum_reg} + {{(eud_pkg::SUM_W + 1 - eud_pkg::SQ_W){1'b0}}, sq_reg};

    always_comb
    begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
            ovf_next = 1'b0;
        end
        else if (ctrl.acc_en)
        begin
            // A carry out of the sum width means the sum would pass its maximum.
            if (total[eud_pkg::SUM_W])
            begin
                sum_next = '1;
                ovf_next = 1'b1;
            end
            else
            begin
                sum_next = total[eud_pkg::SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.square_en)
        begin
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    assign sum      = sum_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire

// ===== sv/eud_sqrt.sv =====
// ----------------------------------------------------------------------------
// eud_sqrt
// Iterative floor square root, one result bit per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eud_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [eud_pkg::SUM_W-1:0]     operand,
    output eud_pkg::sqrt_stat_t                stat,
    output logic      [eud_pkg::DIST_W-1:0]    root
);

    logic [eud_pkg::OPND_W-1:0]     op_reg;
    logic [eud_pkg::OPND_W-1:0]     op_next;
    logic [eud_pkg::REM_W-1:0]      rem_reg;
    logic [eud_pkg::REM_W-1:0]      rem_next;
    logic [eud_pkg::DIST_W-1:0]     root_reg;
    logic [eud_pkg::DIST_W-1:0]     root_next;
    logic [eud_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic [eud_pkg::STEP_CNT_W-1:0] cnt_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [eud_pkg::REM_W+1:0]      shifted;
    logic [eud_pkg::REM_W+1:0]      trial;
    logic [eud_pkg::REM_W+1:0]      diff;

    // Bring down the next two operand bits and try the next root bit.
    assign shifted = {rem_reg, op_reg[eud_pkg::OPND_W-1 -: 2]};
    assign trial   = {{(eud_pkg::REM_W + 2 - eud_pkg::DIST_W - 2){1'b0}}, root_reg, 2'b01};
    assign diff    = shifted - trial;

    always_comb
    begin
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            op_next   = {{(eud_pkg::OPND_W - eud_pkg::SUM_W){1'b0}}, operand};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = eud_pkg::STEP_CNT_W'(eud_pkg::ROOT_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            op_next = {op_reg[eud_pkg::OPND_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = diff[eud_pkg::REM_W-1:0];
                root_next = {root_reg[eud_pkg::DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[eud_pkg::REM_W-1:0];
                root_next = {root_reg[eud_pkg::DIST_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == eud_pkg::STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

`default_nettype wire

// ===== sv/euclidean_distance_unit.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_unit
// Streams coordinate pairs of two vectors and returns their L2 distance.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one coordinate pair (coord_a, coord_b,
// unsigned Q0.16) and a last flag. The block squares the difference of the
// pair and adds it to a 45-bit running sum that saturates at its maximum.
// On the transfer marked last it takes the floor square root of the sum and
// offers one output transfer: distance (Q7.16) and saturated, which reports
// whether the sum clipped anywhere in that vector. The sum then clears.
// Flow: a pair that is not last holds in_ready low while it is squared and
// then added (ST_SQUARE, ST_ACCUM), so the next pair waits for both. A last
// pair then passes ST_ROOT_LOAD and the bit-serial root unit (one result bit
// per cycle, in ST_ROOT_WAIT) before ST_DELIVER hands it off; out_valid rises
// when in_ready also returns.
// A finished result sits in the output register; input transfers for the next
// vector continue while it waits. Only when a second distance is ready while
// the first is still stalled does the sequencer hold, and in_ready stays low
// until the receiver takes the first result.
// Reset clears the sum, the saturation flag, the sequencer and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_distance_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [eud_pkg::COORD_W-1:0]   coord_a,
    input  wire logic [eud_pkg::COORD_W-1:0]   coord_b,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [eud_pkg::DIST_W-1:0]    distance,
    output logic                               saturated
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT_LOAD,
        ST_ROOT_WAIT,
        ST_DELIVER
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [eud_pkg::COORD_W-1:0] coord_a_reg;
    logic [eud_pkg::COORD_W-1:0] coord_b_reg;
    logic                        last_reg;
    logic                        sat_hold_reg;
    logic                        sat_hold_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [eud_pkg::DIST_W-1:0]  distance_reg;
    logic [eud_pkg::DIST_W-1:0]  distance_next;
    logic                        saturated_reg;
    logic                        saturated_next;

    logic                        in_xfer;
    logic                        sqrt_start;
    eud_pkg::sq_ctrl_t           sq_ctrl;
    eud_pkg::sqrt_stat_t         sqrt_stat;
    logic [eud_pkg::SUM_W-1:0]   sum;
    logic                        overflow;
    logic [eud_pkg::DIST_W-1:0]  root;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // The square is formed the cycle after the transfer, added the cycle after
    // that. Loading the root unit and clearing the sum happen together.
    assign sq_ctrl.square_en = (state_reg == ST_SQUARE);
    assign sq_ctrl.acc_en    = (state_reg == ST_ACCUM);
    assign sq_ctrl.clear     = (state_reg == ST_ROOT_LOAD);
    assign sqrt_start        = (state_reg == ST_ROOT_LOAD);

    eud_sqsum u_sqsum (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (sq_ctrl),
        .coord_a  (coord_a_reg),
        .coord_b  (coord_b_reg),
        .sum      (sum),
        .overflow (overflow)
    );

    eud_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sum),
        .stat    (sqrt_stat),
        .root    (root)
    );

    always_comb
    begin
        state_next     = state_reg;
        sat_hold_next  = sat_hold_reg;
        distance_next  = distance_reg;
        saturated_next = saturated_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = last_reg ? ST_ROOT_LOAD : ST_IDLE;
            end
            ST_ROOT_LOAD:
            begin
                // The flag must be kept here since the sum clears this cycle.
                sat_hold_next = overflow;
                state_next    = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sqrt_stat.done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                // Wait only while an older result is still stalled.
                if (!out_valid_reg || out_ready)
                begin
                    distance_next  = root;
                    saturated_next = sat_hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sat_hold_reg  <= 1'b0;
            distance_reg  <= '0;
            saturated_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sat_hold_reg  <= sat_hold_next;
            distance_reg  <= distance_next;
            saturated_reg <= saturated_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            coord_a_reg <= coord_a;
            coord_b_reg <= coord_b;
            last_reg    <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign saturated = saturated_reg;

    // The root unit finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_stat.done |-> (state_reg == ST_ROOT_WAIT))
        else $error("root unit finished outside the wait state");

    // Loading the root unit leaves the running sum and its flag cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT_LOAD) |=> (sum == '0) && !overflow)
        else $error("sum not cleared after a distance was started");

    // No new pair is taken while the root unit is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_stat.busy |-> !in_ready)
        else $error("input taken while the root unit is busy");

    // A stalled result is never overwritten by the next distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(distance) && $stable(saturated))
        else $error("stalled result changed");

endmodule

`default_nettype wire
